/* src/ecpu_pkg.sv */
// Shared types and constants for the 8-bit CPU ALU with flags.
package ecpu_pkg;

  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  localparam logic [7:0] DaaLoAdj = 8'h06;
  localparam logic [7:0] DaaHiAdj = 8'h60;
  localparam logic [7:0] DaaHiMax = 8'h99;
  localparam logic [3:0] DaaLoMax = 4'h9;

  typedef enum logic [4:0] {
    OpAdd   = 5'd0,
    OpAdc   = 5'd1,
    OpSub   = 5'd2,
    OpSbc   = 5'd3,
    OpAnd   = 5'd4,
    OpOr    = 5'd5,
    OpXor   = 5'd6,
    OpCp    = 5'd7,
    OpInc   = 5'd8,
    OpDec   = 5'd9,
    OpAdd16 = 5'd10,
    OpInc16 = 5'd11,
    OpDec16 = 5'd12,
    OpRlc   = 5'd13,
    OpRrc   = 5'd14,
    OpRl    = 5'd15,
    OpRr    = 5'd16,
    OpSla   = 5'd17,
    OpSra   = 5'd18,
    OpSrl   = 5'd19,
    OpSwap  = 5'd20,
    OpBit   = 5'd21,
    OpSet   = 5'd22,
    OpRes   = 5'd23,
    OpDaa   = 5'd24
  } alu_op_e;

  typedef struct packed {
    logic [4:0]  action;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic [3:0]  flags_in;
  } alu_req_t;

  typedef struct packed {
    logic [15:0] result_value;
    logic [3:0]  flags_out;
    logic        write_back;
  } alu_res_t;

endpackage

/* src/ecpu_alu.sv */
// Combinational ALU datapath: result value, flags and write-back strobe.
module ecpu_alu (
  input  ecpu_pkg::alu_req_t req_i,
  output ecpu_pkg::alu_res_t res_o
);

  ecpu_pkg::alu_op_e op;
  logic [7:0]  a, b, res8, bmask, daa_v;
  logic [15:0] res16;
  logic [3:0]  f;
  logic        wb, cin, use16, cuse;
  logic [8:0]  sum9, dif9;
  logic [4:0]  hsum5, hdif5;
  logic [16:0] sum17;
  logic [12:0] hsum13;
  logic        daa_c;

  assign op    = ecpu_pkg::alu_op_e'(req_i.action);
  assign a     = req_i.operand_a[7:0];
  assign b     = req_i.operand_b[7:0];
  assign cin   = req_i.flags_in[ecpu_pkg::FlagC];
  assign cuse  = (op == ecpu_pkg::OpAdc || op == ecpu_pkg::OpSbc) ? cin : 1'b0;
  assign bmask = 8'(1) << req_i.bit_index;

  assign sum9   = {1'b0, a} + {1'b0, b} + {8'd0, cuse};
  assign hsum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cuse};
  assign dif9   = {1'b0, a} - {1'b0, b} - {8'd0, cuse};
  assign hdif5  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cuse};
  assign sum17  = {1'b0, req_i.operand_a} + {1'b0, req_i.operand_b};
  assign hsum13 = {1'b0, req_i.operand_a[11:0]} + {1'b0, req_i.operand_b[11:0]};

  always_comb begin
    daa_v = a;
    daa_c = cin;
    if (!req_i.flags_in[ecpu_pkg::FlagN]) begin
      if (cin || a > ecpu_pkg::DaaHiMax) begin
        daa_v = daa_v + ecpu_pkg::DaaHiAdj;
        daa_c = 1'b1;
      end
      if (req_i.flags_in[ecpu_pkg::FlagH] || a[3:0] > ecpu_pkg::DaaLoMax) begin
        daa_v = daa_v + ecpu_pkg::DaaLoAdj;
      end
    end else begin
      if (cin) begin
        daa_v = daa_v - ecpu_pkg::DaaHiAdj;
      end
      if (req_i.flags_in[ecpu_pkg::FlagH]) begin
        daa_v = daa_v - ecpu_pkg::DaaLoAdj;
      end
    end
  end

  always_comb begin
    res8  = a;
    res16 = req_i.operand_a;
    use16 = 1'b0;
    f     = req_i.flags_in;
    wb    = 1'b1;
    case (op)
      ecpu_pkg::OpAdd, ecpu_pkg::OpAdc: begin
        res8 = sum9[7:0];
        f    = {(sum9[7:0] == 8'd0), 1'b0, hsum5[4], sum9[8]};
      end
      ecpu_pkg::OpSub, ecpu_pkg::OpSbc: begin
        res8 = dif9[7:0];
        f    = {(dif9[7:0] == 8'd0), 1'b1, hdif5[4], dif9[8]};
      end
      ecpu_pkg::OpCp: begin
        f  = {(dif9[7:0] == 8'd0), 1'b1, hdif5[4], dif9[8]};
        wb = 1'b0;
      end
      ecpu_pkg::OpAnd: begin
        res8 = a & b;
        f    = {((a & b) == 8'd0), 1'b0, 1'b1, 1'b0};
      end
      ecpu_pkg::OpOr: begin
        res8 = a | b;
        f    = {((a | b) == 8'd0), 3'b000};
      end
      ecpu_pkg::OpXor: begin
        res8 = a ^ b;
        f    = {((a ^ b) == 8'd0), 3'b000};
      end
      ecpu_pkg::OpInc: begin
        res8 = a + 8'd1;
        f    = {(a == 8'hFF), 1'b0, (a[3:0] == 4'hF), cin};
      end
      ecpu_pkg::OpDec: begin
        res8 = a - 8'd1;
        f    = {(a == 8'h01), 1'b1, (a[3:0] == 4'h0), cin};
      end
      ecpu_pkg::OpAdd16: begin
        use16 = 1'b1;
        res16 = sum17[15:0];
        f     = {req_i.flags_in[ecpu_pkg::FlagZ], 1'b0, hsum13[12], sum17[16]};
      end
      ecpu_pkg::OpInc16: begin
        use16 = 1'b1;
        res16 = req_i.operand_a + 16'd1;
      end
      ecpu_pkg::OpDec16: begin
        use16 = 1'b1;
        res16 = req_i.operand_a - 16'd1;
      end
      ecpu_pkg::OpRlc: begin
        res8 = {a[6:0], a[7]};
        f    = {(a == 8'd0), 2'b00, a[7]};
      end
      ecpu_pkg::OpRrc: begin
        res8 = {a[0], a[7:1]};
        f    = {(a == 8'd0), 2'b00, a[0]};
      end
      ecpu_pkg::OpRl: begin
        res8 = {a[6:0], cin};
        f    = {({a[6:0], cin} == 8'd0), 2'b00, a[7]};
      end
      ecpu_pkg::OpRr: begin
        res8 = {cin, a[7:1]};
        f    = {({cin, a[7:1]} == 8'd0), 2'b00, a[0]};
      end
      ecpu_pkg::OpSla: begin
        res8 = {a[6:0], 1'b0};
        f    = {(a[6:0] == 7'd0), 2'b00, a[7]};
      end
      ecpu_pkg::OpSra: begin
        res8 = {a[7], a[7:1]};
        f    = {(a[7:1] == 7'd0), 2'b00, a[0]};
      end
      ecpu_pkg::OpSrl: begin
        res8 = {1'b0, a[7:1]};
        f    = {(a[7:1] == 7'd0), 2'b00, a[0]};
      end
      ecpu_pkg::OpSwap: begin
        res8 = {a[3:0], a[7:4]};
        f    = {(a == 8'd0), 3'b000};
      end
      ecpu_pkg::OpBit: begin
        f  = {((a & bmask) == 8'd0), 1'b0, 1'b1, cin};
        wb = 1'b0;
      end
      ecpu_pkg::OpSet: begin
        res8 = a | bmask;
      end
      ecpu_pkg::OpRes: begin
        res8 = a & ~bmask;
      end
      ecpu_pkg::OpDaa: begin
        res8 = daa_v;
        f    = {(daa_v == 8'd0), req_i.flags_in[ecpu_pkg::FlagN], 1'b0, daa_c};
      end
      default: begin
        wb = 1'b0;
      end
    endcase
  end

  assign res_o.result_value = use16 ? res16 : {8'd0, res8};
  assign res_o.flags_out    = f;
  assign res_o.write_back   = wb;

endmodule

/* src/eight_bit_cpu_alu_with_flags_core.sv */
// Top level of the 8-bit CPU ALU with flags: request and result registers.
//
// Request channel: in_valid_i / in_ready_o carry action, two 16-bit operands,
// a bit index and the incoming Z/N/H/C flags. Result channel: out_valid_o /
// out_ready_i carry the 16-bit result, the new flags and the write-back
// strobe. Every request gives exactly one result, in order.
// A request is captured in an input register; the ALU logic between that
// register and the result register computes everything in one pass.
// An accepted request passes through the input register and then the result
// register, and out_valid_o rises once its result is in the result register.
// Throughput: one request per cycle while the receiver takes results.
// When the receiver stalls, the result register holds; one more request can
// still be taken into the input register, after which in_ready_o drops.
// Reset (rst_ni low, asynchronous) empties both registers; payload is kept.
module eight_bit_cpu_alu_with_flags_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [4:0]  action_i,
  input  logic [15:0] operand_a_i,
  input  logic [15:0] operand_b_i,
  input  logic [2:0]  bit_index_i,
  input  logic [3:0]  flags_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] result_value_o,
  output logic [3:0]  flags_out_o,
  output logic        write_back_o
);

  logic                req_valid_q;
  ecpu_pkg::alu_req_t  req_q;
  logic                res_valid_q;
  ecpu_pkg::alu_res_t  res_q;
  ecpu_pkg::alu_res_t  res_d;
  logic                res_ready;

  assign res_ready  = !res_valid_q || out_ready_i;
  assign in_ready_o = !req_valid_q || res_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q.action    <= action_i;
      req_q.operand_a <= operand_a_i;
      req_q.operand_b <= operand_b_i;
      req_q.bit_index <= bit_index_i;
      req_q.flags_in  <= flags_in_i;
    end
  end

  ecpu_alu u_alu (
    .req_i (req_q),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_ready) begin
      res_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && req_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = res_valid_q;
  assign result_value_o = res_q.result_value;
  assign flags_out_o    = res_q.flags_out;
  assign write_back_o   = res_q.write_back;

`ifndef ASSERT_OFF
  a_req_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> req_valid_q)
    else $error("accepted request not held in input register");

  a_req_to_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && res_ready) |=> res_valid_q)
    else $error("request lost between input and result register");

  a_req_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && !res_ready) |=> (req_valid_q && $stable(req_q)))
    else $error("stalled request changed");

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (req_valid_q && res_valid_q && !out_ready_i))
    else $error("input stalled while pipeline has room");
`endif

endmodule
